>>> design/pnmt_pkg.sv
// Shared types, codes and constants of the peer node table.
package pnmt_pkg;

  localparam int unsigned EntriesDefault = 32;
  localparam logic [15:0] HoldReset      = 16'd120;

  localparam int unsigned InDataW  = 120;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 152;
  localparam int unsigned OutUserW = 1;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_AGE    = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef struct packed {
    logic [47:0]        key;
    logic [31:0]        seen;
    logic [31:0]        packets;
    logic [7:0]         role;
    logic [7:0]         hops;
    logic               direct;
    logic signed [8:0]  rssi;
    logic signed [7:0]  snr;
  } entry_t;

  typedef struct packed {
    logic       valid;
    entry_t     entry;
    logic [5:0] used;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan_init;
    logic scan_step;
    logic resolve;
    logic shift_init;
    logic shift_step;
    logic front_wr;
    logic age_init;
    logic age_step;
    logic read_issue;
    logic res_read;
    logic res_empty;
    logic push;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic op_update;
    logic op_age;
    logic op_read;
    logic pass_done;
    logic out_free;
  } sts_t;

endpackage

>>> design/pnmt_ctrl.sv
// Sequencer for the peer node table: item intake, table passes, result hand-off.
module pnmt_ctrl import pnmt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_DISPATCH   = 4'd1;
  localparam logic [3:0] S_SCAN       = 4'd2;
  localparam logic [3:0] S_RESOLVE    = 4'd3;
  localparam logic [3:0] S_SHIFT_INIT = 4'd4;
  localparam logic [3:0] S_SHIFT      = 4'd5;
  localparam logic [3:0] S_FRONT      = 4'd6;
  localparam logic [3:0] S_AGE        = 4'd7;
  localparam logic [3:0] S_RD_DATA    = 4'd8;
  localparam logic [3:0] S_EMPTY      = 4'd9;
  localparam logic [3:0] S_DONE       = 4'd10;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts_i.op_update) begin
          cmd_o.scan_init = 1'b1;
          state_d         = S_SCAN;
        end else if (sts_i.op_age) begin
          cmd_o.age_init = 1'b1;
          state_d        = S_AGE;
        end else if (sts_i.op_read) begin
          cmd_o.read_issue = 1'b1;
          state_d          = S_RD_DATA;
        end else begin
          state_d = S_EMPTY;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.pass_done) state_d = S_RESOLVE;
      end
      S_RESOLVE: begin
        cmd_o.resolve = 1'b1;
        state_d       = S_SHIFT_INIT;
      end
      S_SHIFT_INIT: begin
        cmd_o.shift_init = 1'b1;
        state_d          = S_SHIFT;
      end
      S_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        if (sts_i.pass_done) state_d = S_FRONT;
      end
      S_FRONT: begin
        cmd_o.front_wr = 1'b1;
        state_d        = S_DONE;
      end
      S_AGE: begin
        cmd_o.age_step = 1'b1;
        if (sts_i.pass_done) state_d = S_EMPTY;
      end
      S_RD_DATA: begin
        cmd_o.res_read = 1'b1;
        state_d        = S_DONE;
      end
      S_EMPTY: begin
        cmd_o.res_empty = 1'b1;
        state_d         = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/pnmt_dp.sv
// Datapath of the peer node table: entry memory, pass counters, search, result registers.
module pnmt_dp import pnmt_pkg::*; #(
  parameter int unsigned ENTRIES = EntriesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic [InDataW-1:0]   in_data_i,
  input  logic [InUserW-1:0]   in_user_i,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OutDataW-1:0]  out_data_o,
  output logic [OutUserW-1:0]  out_user_o
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned UW = AW + 1;
  localparam logic [UW-1:0] EntriesU = UW'(ENTRIES);

  // entry memory, one write and one registered read per cycle
  entry_t mem_q [ENTRIES];
  entry_t rdata_q;
  logic   mem_we;
  logic [AW-1:0] wr_addr, rd_addr;
  entry_t wr_data;
  logic   rd_en;

  // item registers
  entry_t     new_q;
  logic [1:0] op_q;
  logic [4:0] idx_q;

  // control state
  logic [UW-1:0] used_q, cnt_q, cnt_m1;
  logic [15:0]   hold_q;
  logic          done_q, hit_q, rvld_q, out_valid_q;
  logic [AW-1:0] raddr_q, pos_q, min_pos_q;
  logic [31:0]   min_seen_q, pkt_q;
  result_t       res_q, out_q;

  logic          room, arr_last, key_match, older, age_hit;
  logic          shift_wr, age_wr, in_range;
  entry_t        front_entry, aged_entry;
  logic [UW+5:0] used_x;
  logic [5:0]    used6;
  logic [AW+4:0] idx_w;

  assign room      = used_q < EntriesU;
  assign arr_last  = (({1'b0, raddr_q} + 1'b1) == used_q);
  assign key_match = (rdata_q.key == new_q.key);
  assign older     = (raddr_q == '0) || (rdata_q.seen < min_seen_q);
  assign age_hit   = rdata_q.direct && ((new_q.seen - rdata_q.seen) > {16'b0, hold_q});
  assign shift_wr  = cmd_i.shift_step && rvld_q;
  assign age_wr    = cmd_i.age_step && rvld_q && age_hit;
  assign used_x    = {6'b0, used_q};
  assign used6     = used_x[5:0];
  assign idx_w     = {{AW{1'b0}}, idx_q};
  assign in_range  = {{UW{1'b0}}, idx_q} < {5'b0, used_q};
  assign cnt_m1    = cnt_q - 1'b1;

  always_comb begin
    front_entry         = new_q;
    front_entry.packets = pkt_q + 32'd1;
    aged_entry          = rdata_q;
    aged_entry.direct   = 1'b0;
    aged_entry.rssi     = '0;
    aged_entry.snr      = '0;
  end

  // read port select
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cnt_q[AW-1:0];
    if (cmd_i.scan_step) begin
      rd_en = !done_q && (cnt_q < used_q);
    end else if (cmd_i.age_step) begin
      rd_en = cnt_q < used_q;
    end else if (cmd_i.shift_step) begin
      rd_en   = (cnt_q != '0);
      rd_addr = cnt_m1[AW-1:0];
    end else if (cmd_i.read_issue) begin
      rd_en   = 1'b1;
      rd_addr = idx_w[AW-1:0];
    end
  end

  // write port select
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = '0;
    wr_data = front_entry;
    if (cmd_i.front_wr) begin
      mem_we = 1'b1;
    end else if (shift_wr) begin
      mem_we  = 1'b1;
      wr_addr = raddr_q + 1'b1;
      wr_data = rdata_q;
    end else if (age_wr) begin
      mem_we  = 1'b1;
      wr_addr = raddr_q;
      wr_data = aged_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[wr_addr] <= wr_data;
    rdata_q <= mem_q[rd_addr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      hold_q      <= HoldReset;
      cnt_q       <= '0;
      done_q      <= 1'b0;
      hit_q       <= 1'b0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rvld_q <= rd_en;
      if (cfg_we_i) hold_q <= cfg_wdata_i;

      if (cmd_i.scan_init || cmd_i.age_init) begin
        cnt_q  <= '0;
        done_q <= (used_q == '0);
      end else if (cmd_i.shift_init) begin
        cnt_q  <= {1'b0, pos_q};
        done_q <= (pos_q == '0);
      end else if (rd_en && cmd_i.shift_step) begin
        cnt_q <= cnt_m1;
      end else if (rd_en) begin
        cnt_q <= cnt_q + 1'b1;
      end

      if (cmd_i.scan_init) hit_q <= 1'b0;

      if (cmd_i.scan_step && rvld_q && !done_q) begin
        if (key_match) begin
          hit_q  <= 1'b1;
          done_q <= 1'b1;
        end else if (arr_last) begin
          done_q <= 1'b1;
        end
      end
      if (shift_wr && (raddr_q == '0)) done_q <= 1'b1;
      if (cmd_i.age_step && rvld_q && arr_last) done_q <= 1'b1;

      if (cmd_i.resolve && !hit_q && room) used_q <= used_q + 1'b1;

      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    raddr_q <= rd_addr;
    if (cmd_i.load) begin
      op_q          <= in_user_i;
      idx_q         <= in_data_i[118:114];
      new_q.key     <= in_data_i[47:0];
      new_q.seen    <= in_data_i[79:48];
      new_q.packets <= '0;
      new_q.role    <= in_data_i[87:80];
      new_q.hops    <= in_data_i[95:88];
      new_q.direct  <= in_data_i[96];
      new_q.rssi    <= in_data_i[96] ? in_data_i[105:97] : 9'd0;
      new_q.snr     <= in_data_i[96] ? in_data_i[113:106] : 8'd0;
    end
    if (cmd_i.scan_step && rvld_q && !done_q) begin
      if (key_match) begin
        pos_q <= raddr_q;
        pkt_q <= rdata_q.packets;
      end else if (older) begin
        min_seen_q <= rdata_q.seen;
        min_pos_q  <= raddr_q;
      end
    end
    if (cmd_i.resolve && !hit_q) begin
      pkt_q <= '0;
      pos_q <= room ? used_q[AW-1:0] : min_pos_q;
    end
    if (cmd_i.front_wr) begin
      res_q.valid <= hit_q;
      res_q.entry <= front_entry;
      res_q.used  <= used6;
    end else if (cmd_i.res_read) begin
      res_q.valid <= in_range;
      res_q.entry <= in_range ? rdata_q : '0;
      res_q.used  <= used6;
    end else if (cmd_i.res_empty) begin
      res_q.valid <= 1'b0;
      res_q.entry <= '0;
      res_q.used  <= used6;
    end
    if (cmd_i.push) out_q <= res_q;
  end

  assign sts_o.op_update = (op_q == OP_UPDATE);
  assign sts_o.op_age    = (op_q == OP_AGE);
  assign sts_o.op_read   = (op_q == OP_READ);
  assign sts_o.pass_done = done_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_user_o  = out_q.valid;
  assign out_data_o  = {out_q.used, out_q.entry.snr, out_q.entry.rssi, out_q.entry.direct,
                        out_q.entry.hops, out_q.entry.role, out_q.entry.packets,
                        out_q.entry.seen, out_q.entry.key};

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= EntriesU)
    else $error("occupancy exceeds table size");

  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != $past(used_q)) |-> (used_q == $past(used_q) + 1'b1))
    else $error("occupancy changed by other than one");

  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.front_wr, shift_wr, age_wr}))
    else $error("more than one memory write source");

  a_shift_not_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift_wr |-> (wr_addr != '0))
    else $error("shift wrote the front slot");

endmodule

>>> design/peer_node_mru_table.sv
// Top level of the peer node table: most recently heard nodes, newest first.
// Update: one search pass plus one shift pass through the entry memory (one write port and one
// registered read port), one entry per cycle each; age: one pass over the occupied entries;
// read: one memory read; op 3: an empty result, as for an age.
// Intake: one item at a time; the next item is taken while a result waits.
// Reset: asynchronous, active low; occupancy and output valid clear, hold time returns to 120 s;
// entry memory is not cleared; contents of unoccupied positions are never returned.
module peer_node_mru_table import pnmt_pkg::*; #(
  parameter int unsigned ENTRIES = EntriesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i,   // signal_hold_seconds
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [47:0] node_key, [79:48] time_seconds, [87:80] node_role, [95:88] hop_count,
  // [96] signal_is_direct, [105:97] rssi_in, [113:106] snr_in, [118:114] entry_index, [119] 0
  input  logic [InDataW-1:0]   s_axis_tdata,
  input  logic [InUserW-1:0]   s_axis_tuser,  // [1:0] op
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [47:0] entry_key, [79:48] entry_last_seen, [111:80] entry_packets, [119:112] entry_role,
  // [127:120] entry_hops, [128] entry_signal_valid, [137:129] entry_rssi,
  // [145:138] entry_snr, [151:146] entries_used
  output logic [OutDataW-1:0]  m_axis_tdata,
  output logic [OutUserW-1:0]  m_axis_tuser   // [0] entry_valid
);

  cmd_t cmd;
  sts_t sts;

  // Controller: walks each item through dispatch, table passes and result hand-off.
  pnmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: update = search pass (hit, else free or oldest slot), then shift pass moving
  // entries ahead of the chosen slot back by one, then the new front write.
  pnmt_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the peer node table: random stream traffic checked against a model.
`timescale 1ns / 1ps

module testbench;
  import pnmt_pkg::*;

  localparam int unsigned TableSize     = EntriesDefault;
  localparam int unsigned CycleLimit    = 1_000_000;
  localparam int unsigned KeyPoolSize   = 40;   // more keys than rows, so the table fills and evicts
  localparam int unsigned ItemsPerPhase = 250;
  localparam int unsigned DrainCycles   = 80;   // settle time after the last result
  localparam logic [1:0]  OpSpare       = 2'd3; // unused code, answered like an age

  // one input item, fields as the block sees them
  typedef struct packed {
    logic [1:0]        op;
    logic [47:0]       node_key;
    logic [31:0]       stamp;
    logic [7:0]        role;
    logic [7:0]        hops;
    logic              direct;
    logic signed [8:0] rssi;
    logic signed [7:0] snr;
    logic [4:0]        idx;
  } req_t;

  // mirror of the table; predicts the reply to each accepted item and checks it on return
  class peer_table_scoreboard;
    entry_t      rows[TableSize];
    int unsigned used;
    logic [15:0] hold_s;
    result_t     pending_replies[$];
    int unsigned errors;

    function new();
      used   = 0;
      hold_s = HoldReset;
      errors = 0;
      foreach (rows[i]) rows[i] = '0;
    endfunction

    function void note_request(req_t r);
      result_t     reply;
      entry_t      fresh;
      int          pos;
      bit          hit;
      logic [31:0] oldest;
      logic [31:0] silence;
      reply = '0;
      fresh = '0;
      pos   = 0;
      hit   = 1'b0;
      if (r.op == OP_UPDATE) begin
        for (int i = 0; i < int'(used); i++) begin
          if (!hit && rows[i].key == r.node_key) begin
            hit = 1'b1;
            pos = i;
          end
        end
        fresh.packets = 32'd1;
        if (hit) begin
          fresh.packets = rows[pos].packets + 32'd1;
        end else if (used < TableSize) begin
          pos = used;
          used++;
        end else begin
          // evict the oldest sighting, first in table order on a tie
          oldest = rows[0].seen;
          for (int i = 1; i < int'(TableSize); i++) begin
            if (rows[i].seen < oldest) begin
              oldest = rows[i].seen;
              pos    = i;
            end
          end
        end
        for (int i = pos; i > 0; i--) rows[i] = rows[i-1];
        fresh.key    = r.node_key;
        fresh.seen   = r.stamp;
        fresh.role   = r.role;
        fresh.hops   = r.hops;
        fresh.direct = r.direct;
        fresh.rssi   = r.direct ? r.rssi : '0;
        fresh.snr    = r.direct ? r.snr : '0;
        rows[0]      = fresh;
        reply.valid  = hit;
        reply.entry  = fresh;
      end else if (r.op == OP_AGE) begin
        for (int i = 0; i < int'(used); i++) begin
          silence = r.stamp - rows[i].seen;  // wraps at 32 bits
          if (rows[i].direct && silence > {16'd0, hold_s}) begin
            rows[i].direct = 1'b0;
            rows[i].rssi   = '0;
            rows[i].snr    = '0;
          end
        end
      end else if (r.op == OP_READ) begin
        if (r.idx < used) begin
          reply.valid = 1'b1;
          reply.entry = rows[r.idx];
        end
      end
      reply.used = 6'(used);
      pending_replies.push_back(reply);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_reply(logic [OutDataW-1:0] d, logic [OutUserW-1:0] u);
      result_t got;
      result_t want;
      got.valid        = u[0];
      got.entry.key    = d[47:0];
      got.entry.seen   = d[79:48];
      got.entry.packets = d[111:80];
      got.entry.role   = d[119:112];
      got.entry.hops   = d[127:120];
      got.entry.direct = d[128];
      got.entry.rssi   = d[137:129];
      got.entry.snr    = d[145:138];
      got.used         = d[151:146];
      if (pending_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %0h/%0h", $time, u, d);
        return;
      end
      want = pending_replies.pop_front();
      compare_field("entry_valid", want.valid, got.valid);
      compare_field("entry_key", want.entry.key, got.entry.key);
      compare_field("entry_last_seen", want.entry.seen, got.entry.seen);
      compare_field("entry_packets", want.entry.packets, got.entry.packets);
      compare_field("entry_role", want.entry.role, got.entry.role);
      compare_field("entry_hops", want.entry.hops, got.entry.hops);
      compare_field("entry_signal_valid", want.entry.direct, got.entry.direct);
      compare_field("entry_rssi", 64'(unsigned'(want.entry.rssi)),
                    64'(unsigned'(got.entry.rssi)));
      compare_field("entry_snr", 64'(unsigned'(want.entry.snr)),
                    64'(unsigned'(got.entry.snr)));
      compare_field("entries_used", want.used, got.used);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [15:0]         cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [InUserW-1:0]  s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;

  peer_table_scoreboard sb = new();
  int unsigned          cycle_count = 0;
  logic [31:0]          clock_now;
  logic [47:0]          key_pool[KeyPoolSize];
  bit                   sender_quiet;

  peer_node_mru_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog: a run that hangs ends here
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** peer_node_mru_table: FAILED **");
    $finish;
  end

  function automatic req_t make_req(logic [1:0] op, logic [47:0] k, logic [31:0] t,
                                    logic [7:0] role, logic [7:0] hops, logic dir,
                                    logic signed [8:0] rssi, logic signed [7:0] snr,
                                    logic [4:0] idx);
    req_t r;
    r.op       = op;
    r.node_key = k;
    r.stamp    = t;
    r.role     = role;
    r.hops     = hops;
    r.direct   = dir;
    r.rssi     = rssi;
    r.snr      = snr;
    r.idx      = idx;
    return r;
  endfunction

  // Mostly sightings of a recurring peer set with slowly advancing time (ties are
  // common, so eviction order on equal times gets exercised); some reads, ages and
  // noise (stray keys, arbitrary times, the unused op code).
  function automatic req_t random_request();
    req_t        r;
    int unsigned pick;
    pick       = $urandom_range(0, 99);
    r.node_key = ($urandom_range(0, 19) == 0) ? 48'({$urandom(), $urandom()})
                                             : key_pool[$urandom_range(0, KeyPoolSize-1)];
    r.role     = 8'($urandom());
    r.hops     = 8'($urandom());
    r.direct   = ($urandom_range(0, 3) != 0);
    r.rssi     = 9'($urandom());
    r.snr      = 8'($urandom());
    r.idx      = 5'($urandom());
    r.stamp    = $urandom();
    if (pick < 55) begin
      r.op = OP_UPDATE;
      if ($urandom_range(0, 9) != 0) begin
        clock_now = clock_now + $urandom_range(0, 3);
        r.stamp   = clock_now;
      end
    end else if (pick < 85) begin
      r.op = OP_READ;
      if ($urandom_range(0, 1) == 0 && sb.used > 0) r.idx = 5'($urandom_range(0, sb.used - 1));
    end else if (pick < 96) begin
      r.op = OP_AGE;
      // around the hold boundary most of the time
      if ($urandom_range(0, 7) != 0)
        r.stamp = clock_now + $urandom_range(0, sb.hold_s + sb.hold_s / 2 + 8);
    end else begin
      r.op = OpSpare;
    end
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_item(req_t r);
    int unsigned gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.op;
    s_axis_tdata  <= {1'b0, r.idx, r.snr, r.rssi, r.direct, r.hops, r.role,
                      r.stamp, r.node_key};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(r);
    @(negedge clk_i);
  endtask

  task automatic run_random(int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 40 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
      send_item(random_request());
    end
  endtask

  // let every outstanding result come back, then settle
  task automatic drain(int unsigned settle);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_replies.size() != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic write_hold(logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.hold_s = value;
    @(negedge clk_i);
  endtask

  // result side: random back-pressure with occasional stretches of none
  initial begin : receiver
    int unsigned stall;
    int unsigned taken;
    bit          quiet;
    m_axis_tready = 1'b0;
    taken         = 0;
    quiet         = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (taken % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      stall = quiet ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_reply(m_axis_tdata, m_axis_tuser);
      taken++;
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    logic [15:0] hold_plan[5];
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_READ;
    sender_quiet  = 1'b0;
    clock_now     = $urandom_range(0, 1000);
    foreach (key_pool[i]) key_pool[i] = 48'({$urandom(), $urandom()});
    key_pool[0] = '0;
    key_pool[1] = '1;
    hold_plan   = '{16'd0, 16'd65535, 16'd1, 16'($urandom()), 16'd30};

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty table, field extremes, hit/miss, unattributed signal,
    // hold boundary and time wrap in the age test, out-of-range reads, spare op
    send_item(make_req(OP_READ, '0, '0, '0, '0, 1'b0, '0, '0, 5'd0));
    send_item(make_req(OP_READ, '1, '1, '1, '1, 1'b1, '1, '1, 5'd31));
    send_item(make_req(OP_AGE, '0, '0, '0, '0, 1'b0, '0, '0, 5'd0));
    send_item(make_req(OpSpare, '1, '1, '1, '1, 1'b1, '1, '1, 5'd31));
    send_item(make_req(OP_UPDATE, '0, '0, '0, '0, 1'b1, 9'h100, 8'h80, 5'd0));
    send_item(make_req(OP_UPDATE, '1, '1, 8'hFF, 8'hFF, 1'b1, 9'h0FF, 8'h7F, 5'd0));
    send_item(make_req(OP_UPDATE, '0, 32'd10, 8'd3, 8'd1, 1'b0, 9'd100, 8'hFB, 5'd0));
    send_item(make_req(OP_UPDATE, 48'h5, 32'd100, 8'd1, 8'd2, 1'b1, 9'h1FF, 8'hFF, 5'd0));
    send_item(make_req(OP_AGE, '0, 32'd220, '0, '0, 1'b0, '0, '0, 5'd0));  // exactly at hold
    send_item(make_req(OP_READ, '0, '0, '0, '0, 1'b0, '0, '0, 5'd2));
    send_item(make_req(OP_READ, '0, '0, '0, '0, 1'b0, '0, '0, 5'd0));
    send_item(make_req(OP_AGE, '0, 32'd221, '0, '0, 1'b0, '0, '0, 5'd0));  // one past hold
    send_item(make_req(OP_READ, '0, '0, '0, '0, 1'b0, '0, '0, 5'd0));
    send_item(make_req(OP_READ, '0, '0, '0, '0, 1'b0, '0, '0, 5'd3));
    send_item(make_req(OP_UPDATE, 48'h5, 32'd221, 8'd9, 8'd0, 1'b1, 9'd7, 8'd12, 5'd0));
    send_item(make_req(OP_UPDATE, '1, 32'd222, 8'd4, 8'd4, 1'b1, 9'h1F0, 8'd3, 5'd0));
    send_item(make_req(OP_READ, '0, '0, '0, '0, 1'b0, '0, '0, 5'd1));

    run_random(ItemsPerPhase);
    foreach (hold_plan[p]) begin
      drain(8);
      write_hold(hold_plan[p]);
      if (p == 2) clock_now = 32'hFFFF_FF00;  // sightings straddle the time wrap
      run_random(ItemsPerPhase);
    end

    drain(DrainCycles);
    if (sb.errors == 0 && sb.pending_replies.size() == 0)
      $display("** peer_node_mru_table: PASSED **");
    else
      $display("** peer_node_mru_table: FAILED **");
    $finish;
  end

endmodule

>>> filelist.f
design/pnmt_pkg.sv
design/pnmt_ctrl.sv
design/pnmt_dp.sv
design/peer_node_mru_table.sv
tb/sv/testbench.sv
